### rtl/core/assert_macros.svh
// Assertion macros used by gray_world_white_balance.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWWB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gwwb_pkg.sv
`timescale 1ns / 1ps

package gwwb_pkg;

  localparam int unsigned MAX_PIXELS = 4194304;

  localparam int CHAN_W = 8;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
  localparam logic [CHAN_W-1:0] AVG_RESET = 8'd128;

  localparam int NCH = 3;
  localparam int CH_B = 0;
  localparam int CH_G = 1;
  localparam int CH_R = 2;

  // One quotient bit per cell; the top bit flags a quotient of 256 or more.
  localparam int QBITS = CHAN_W + 1;

  localparam longint unsigned SUM_MAX = 64'(CHAN_MAX) * 64'(MAX_PIXELS);
  localparam int SUM_W = $clog2(SUM_MAX + 64'd1);
  localparam int CNT_W = $clog2(64'(MAX_PIXELS) + 64'd1);
  localparam int PROD_W = 2 * CHAN_W;
  localparam int NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int DEN_W = (CNT_W > CHAN_W) ? CNT_W : CHAN_W;
  localparam int DW = (NUM_W > DEN_W + QBITS - 1) ? NUM_W : DEN_W + QBITS - 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    logic [NCH-1:0][DW-1:0]    rem;
    logic [NCH-1:0][DW-1:0]    dsh;
    logic [NCH-1:0][QBITS-1:0] q;
    logic [NCH-1:0]            nz;
    logic                      is_avg;
    logic                      last;
  } stage_t;

endpackage

### rtl/core/gwwb_div_cell.sv
`timescale 1ns / 1ps

module gwwb_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  gwwb_pkg::stage_t dat_i,
  output logic            vld_o,
  output gwwb_pkg::stage_t dat_o
);
  import gwwb_pkg::*;

  logic [NCH-1:0] ge;
  stage_t         dat_nxt;
  logic           vld_r;
  stage_t         dat_r;

  // Each cell settles one quotient bit per channel and halves the shifted divisor.
  always_comb begin
    dat_nxt = dat_i;
    for (int c = 0; c < NCH; c++) begin
      ge[c] = dat_i.rem[c] >= dat_i.dsh[c];
      dat_nxt.rem[c] = ge[c] ? (dat_i.rem[c] - dat_i.dsh[c]) : dat_i.rem[c];
      dat_nxt.dsh[c] = dat_i.dsh[c] >> 1;
      dat_nxt.q[c] = {dat_i.q[c][QBITS-2:0], ge[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

### rtl/core/gwwb_div_chain.sv
`timescale 1ns / 1ps

module gwwb_div_chain (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  gwwb_pkg::stage_t dat_i,
  output logic            vld_o,
  output gwwb_pkg::stage_t dat_o
);
  import gwwb_pkg::*;

  logic   vld_w [QBITS+1];
  stage_t dat_w [QBITS+1];

  assign vld_w[0] = vld_i;
  assign dat_w[0] = dat_i;

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    gwwb_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (vld_w[k]),
      .dat_i (dat_w[k]),
      .vld_o (vld_w[k+1]),
      .dat_o (dat_w[k+1])
    );
  end

  assign vld_o = vld_w[QBITS];
  assign dat_o = dat_w[QBITS];

endmodule

### rtl/core/gray_world_white_balance.sv
// Gray-world white balance with green as the reference channel. Each frame is
// sent twice: gather items (req_type 0) are summed per channel and counted, and
// the gather item that carries frame_end turns the sums into channel averages;
// correct items (req_type 1) come out scaled by green average over channel
// average, saturated at 255, with frame_end copied to last_out. Gather items
// beyond MAX_PIXELS in one pass are not counted. Items are taken one per clock
// while in_stall is low. A correct item passes through the setup stage, which
// loads at the edge that accepts it, the nine divider cells that each settle
// one quotient bit, and the output register. The same cell chain divides the sums
// by the count, so after the last gather item of a pass the input stalls until
// the new averages leave the chain. A stalled output holds the whole chain.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gray_world_white_balance (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_req_type,
  input  gwwb_pkg::chan_t in_blue_in,
  input  gwwb_pkg::chan_t in_green_in,
  input  gwwb_pkg::chan_t in_red_in,
  input  logic            in_frame_end,
  output logic            out_valid,
  input  logic            out_stall,
  output gwwb_pkg::chan_t out_blue_out,
  output gwwb_pkg::chan_t out_green_out,
  output gwwb_pkg::chan_t out_red_out,
  output logic            out_last_out
);
  import gwwb_pkg::*;

  logic                       adv;
  logic                       in_acc;
  logic                       job_enter;
  logic                       room;
  logic [NCH-1:0][CHAN_W-1:0] pix;
  logic [NCH-1:0][SUM_W-1:0]  sum_inc;
  logic [CNT_W-1:0]           cnt_inc;
  logic [NCH-1:0][PROD_W-1:0] prod;
  stage_t                     prep_nxt;
  logic [NCH-1:0][CHAN_W-1:0] res;

  logic [NCH-1:0][SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [NCH-1:0][CHAN_W-1:0] avg_r;
  logic                       avg_busy_r;
  logic                       prep_vld_r;
  stage_t                     prep_dat_r;
  logic                       tail_vld;
  stage_t                     tail_dat;
  logic                       out_valid_r;
  logic [NCH-1:0][CHAN_W-1:0] res_r;
  logic                       last_r;

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv || avg_busy_r;
  assign in_acc = in_valid && !in_stall;
  assign job_enter = in_acc && (in_req_type || in_frame_end);

  assign pix[CH_B] = in_blue_in;
  assign pix[CH_G] = in_green_in;
  assign pix[CH_R] = in_red_in;

  always_comb begin
    room = cnt_r < CNT_MAX;
    cnt_inc = room ? (cnt_r + CNT_W'(1)) : cnt_r;
    prep_nxt.is_avg = !in_req_type;
    prep_nxt.last = in_frame_end;
    for (int c = 0; c < NCH; c++) begin
      sum_inc[c] = room ? (sum_r[c] + SUM_W'(pix[c])) : sum_r[c];
      prod[c] = {{CHAN_W{1'b0}}, avg_r[CH_G]} * {{CHAN_W{1'b0}}, pix[c]};
      prep_nxt.q[c] = '0;
      if (in_req_type) begin
        prep_nxt.rem[c] = DW'(prod[c]);
        prep_nxt.dsh[c] = DW'(avg_r[c]) << (QBITS - 1);
        prep_nxt.nz[c] = (pix[c] != '0) && (avg_r[CH_G] != '0);
      end else begin
        prep_nxt.rem[c] = DW'(sum_inc[c]);
        prep_nxt.dsh[c] = DW'(cnt_inc) << (QBITS - 1);
        prep_nxt.nz[c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
      for (int c = 0; c < NCH; c++) begin
        avg_r[c] <= AVG_RESET;
      end
      avg_busy_r <= 1'b0;
      prep_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc && !in_req_type) begin
        if (in_frame_end) begin
          sum_r <= '0;
          cnt_r <= '0;
          avg_busy_r <= 1'b1;
        end else begin
          sum_r <= sum_inc;
          cnt_r <= cnt_inc;
        end
      end
      if (adv) begin
        prep_vld_r <= job_enter;
        out_valid_r <= tail_vld && !tail_dat.is_avg;
        if (tail_vld && tail_dat.is_avg) begin
          for (int c = 0; c < NCH; c++) begin
            avg_r[c] <= tail_dat.q[c][QBITS-2:0];
          end
          avg_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_dat_r <= prep_nxt;
    end
  end

  gwwb_div_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (prep_vld_r),
    .dat_i (prep_dat_r),
    .vld_o (tail_vld),
    .dat_o (tail_dat)
  );

  // A quotient of 256 or more saturates; a zero divisor with a zero product gives zero.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (tail_dat.q[c][QBITS-1]) begin
        res[c] = tail_dat.nz[c] ? CHAN_MAX : '0;
      end else begin
        res[c] = tail_dat.q[c][QBITS-2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
      last_r <= tail_dat.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue_out = res_r[CH_B];
  assign out_green_out = res_r[CH_G];
  assign out_red_out = res_r[CH_R];
  assign out_last_out = last_r;

  `GWWB_ASSERT_NEXT(a_avg_job_launch, in_acc && !in_req_type && in_frame_end, avg_busy_r && prep_vld_r && prep_dat_r.is_avg, "Average job did not enter the chain")
  `GWWB_ASSERT_IMPL(a_avg_tail_busy, tail_vld && tail_dat.is_avg, avg_busy_r, "Average job in chain without busy flag")
  `GWWB_ASSERT_IMPL(a_avg_no_sat, tail_vld && tail_dat.is_avg, !tail_dat.q[CH_B][QBITS-1] && !tail_dat.q[CH_G][QBITS-1] && !tail_dat.q[CH_R][QBITS-1], "Channel average overflowed")
  `GWWB_ASSERT_IMPL(a_busy_prep, avg_busy_r, !(prep_vld_r && !prep_dat_r.is_avg), "Pixel entered while averages pending")
  `GWWB_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX, "Pixel count above limit")

endmodule

### test/tb.sv
`timescale 1ns / 1ps

import gwwb_pkg::*;

typedef enum logic {
  REQ_GATHER  = 1'b0,
  REQ_CORRECT = 1'b1
} req_e;

typedef struct packed {
  chan_t blue;
  chan_t green;
  chan_t red;
  logic  last;
} pixel_t;

class wb_tracker;
  longint unsigned sum_b, sum_g, sum_r, count;
  chan_t avg_b, avg_g, avg_r;
  pixel_t owed_pixels[$];
  int errors;

  function new();
    sum_b = 0;
    sum_g = 0;
    sum_r = 0;
    count = 0;
    avg_b = AVG_RESET;
    avg_g = AVG_RESET;
    avg_r = AVG_RESET;
    errors = 0;
  endfunction

  function chan_t scale_channel(chan_t v, chan_t avg);
    logic [15:0] num;
    logic [15:0] q;
    num = {8'd0, avg_g} * {8'd0, v};
    if (avg == '0) begin
      return (num == 16'd0) ? chan_t'(0) : CHAN_MAX;
    end
    q = num / {8'd0, avg};
    return (q > {8'd0, CHAN_MAX}) ? CHAN_MAX : q[7:0];
  endfunction

  function void take_pixel(req_e req, chan_t b, chan_t g, chan_t r, logic fe);
    pixel_t p;
    if (req == REQ_GATHER) begin
      if (count < MAX_PIXELS) begin
        sum_b += b;
        sum_g += g;
        sum_r += r;
        count += 1;
      end
      if (fe) begin
        if (count != 0) begin
          avg_b = chan_t'(sum_b / count);
          avg_g = chan_t'(sum_g / count);
          avg_r = chan_t'(sum_r / count);
        end
        sum_b = 0;
        sum_g = 0;
        sum_r = 0;
        count = 0;
      end
    end else begin
      p.blue = scale_channel(b, avg_b);
      p.green = scale_channel(g, avg_g);
      p.red = scale_channel(r, avg_r);
      p.last = fe;
      owed_pixels = {owed_pixels, p};
    end
  endfunction

  function void compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  function void match_pixel(chan_t b, chan_t g, chan_t r, logic last);
    pixel_t want;
    if (owed_pixels.size() == 0) begin
      $display("%0t: pixel out with none expected: b=%0d g=%0d r=%0d last=%0d",
               $time, b, g, r, last);
      errors++;
      return;
    end
    want = owed_pixels.pop_front();
    compare_field("out_blue_out", want.blue, b);
    compare_field("out_green_out", want.green, g);
    compare_field("out_red_out", want.red, r);
    compare_field("out_last_out", {7'd0, want.last}, {7'd0, last});
  endfunction
endclass

module tb;
  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_req_type = REQ_GATHER;
  chan_t in_blue_in = '0;
  chan_t in_green_in = '0;
  chan_t in_red_in = '0;
  logic  in_frame_end = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  chan_t out_blue_out;
  chan_t out_green_out;
  chan_t out_red_out;
  logic  out_last_out;

  wb_tracker tracker = new();
  int sent = 0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;

  gray_world_white_balance DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_blue_in   (in_blue_in),
    .in_green_in  (in_green_in),
    .in_red_in    (in_red_in),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue_out (out_blue_out),
    .out_green_out(out_green_out),
    .out_red_out  (out_red_out),
    .out_last_out (out_last_out)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.match_pixel(out_blue_out, out_green_out, out_red_out, out_last_out);
    end
  end

  // The long hold-off lets the pipeline fill so that the input side stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (80) @(negedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic chan_t pick_level(int style);
    unique case (style)
      0: pick_level = '0;
      1: pick_level = CHAN_MAX;
      2: pick_level = chan_t'($urandom_range(0, 3));
      default: pick_level = chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(req_e req, chan_t b, chan_t g, chan_t r, logic fe);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_blue_in <= b;
    in_green_in <= g;
    in_red_in <= r;
    in_frame_end <= fe;
    do @(posedge clk); while (in_stall);
    tracker.take_pixel(req, b, g, r, fe);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(int n_gather, int n_correct);
    int sb, sg, sr;
    sb = $urandom_range(0, 9);
    sg = $urandom_range(0, 9);
    sr = $urandom_range(0, 9);
    for (int i = 0; i < n_gather; i++) begin
      send_pixel(REQ_GATHER, pick_level(sb), pick_level(sg), pick_level(sr),
                 i == n_gather - 1);
    end
    for (int i = 0; i < n_correct; i++) begin
      send_pixel(REQ_CORRECT, pick_level($urandom_range(0, 12)),
                 pick_level($urandom_range(0, 12)), pick_level($urandom_range(0, 12)),
                 i == n_correct - 1);
    end
  endtask

  task automatic drain_results();
    int n;
    n = 0;
    while (tracker.owed_pixels.size() != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
  endtask

  initial begin
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity correction straight after reset.
    send_pixel(REQ_CORRECT, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(REQ_CORRECT, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(REQ_CORRECT, 8'h55, 8'hAA, 8'h0F, 1'b0);
    // All averages zero, so every channel comes out zero.
    send_pixel(REQ_GATHER, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(REQ_CORRECT, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(REQ_CORRECT, 8'd255, 8'd1, 8'd7, 1'b1);
    // Zero blue average and saturation on red.
    send_pixel(REQ_GATHER, 8'd0, 8'd255, 8'd1, 1'b1);
    send_pixel(REQ_CORRECT, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(REQ_CORRECT, 8'd1, 8'd200, 8'd3, 1'b1);
    send_pixel(REQ_GATHER, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(REQ_GATHER, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(REQ_GATHER, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(REQ_CORRECT, 8'd255, 8'd128, 8'd0, 1'b1);
    // Averages that round down.
    send_pixel(REQ_GATHER, 8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(REQ_GATHER, 8'd2, 8'd2, 8'd2, 1'b0);
    send_pixel(REQ_GATHER, 8'd2, 8'd3, 8'd3, 1'b1);
    send_pixel(REQ_CORRECT, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(REQ_CORRECT, 8'd100, 8'd50, 8'd1, 1'b1);

    while (sent < 520) begin
      calm = (sent >= 420);
      if (!held && sent >= 150) begin
        held = 1'b1;
        hold_long = 1'b1;
        send_frame(5, 40);
      end else if (!paused && sent >= 300) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        drain_results();
        send_frame($urandom_range(1, 8), $urandom_range(1, 8));
      end else if ($urandom_range(0, 9) < 7) begin
        send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8),
                   $urandom_range(1, 8));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          send_pixel(req_e'($urandom_range(0, 1)), chan_t'($urandom_range(0, 255)),
                     chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end
      end
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (20) @(negedge clk);
    if (tracker.errors == 0 && tracker.owed_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (tracker.owed_pixels.size() != 0) begin
        $display("%0t: %0d expected pixels never came out", $time,
                 tracker.owed_pixels.size());
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
